// ----- src/pts_pkg.sv -----
// Shared types and constants for the priority thread scheduler.
// No dependencies; imported by priority_thread_scheduler_with_sleep.
`default_nettype none

package pts_pkg;

    // Number of user threads (priorities 1..MAX_THREADS); thread 0 is idle
    localparam int MAX_THREADS = 32;

    // Ready bits that belong to threads that can exist
    localparam logic [31:0] THREAD_MASK = (MAX_THREADS >= 32) ? 32'hFFFF_FFFF :
        32'((64'd1 << MAX_THREADS) - 64'd1);

    // Operation codes
    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_SUSPEND = 2'd1;
    localparam logic [1:0] OP_START   = 2'd2;

    // Request word
    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] sleep_ticks;
    } req_t;

    // Response word
    typedef struct packed {
        logic [5:0]  running_thread;
        logic [5:0]  previous_thread;
        logic        switched;
        logic [31:0] ready_bits;
    } rsp_t;

endpackage

`default_nettype wire

// ----- src/priority_thread_scheduler_with_sleep.sv -----
// Priority bitmap thread scheduler with timed sleep (top level).
// Depends on pts_pkg for word types, op codes and the thread mask.
//
//  channel | direction | handshake              | word
//  --------+-----------+------------------------+------------------------------
//  req     | in        | req_valid / req_ready  | pts_pkg::req_t (op, ticks)
//  rsp     | out       | rsp_valid / rsp_ready  | pts_pkg::rsp_t (thread, mask)
//  cfg     | in        | cfg_wr_en              | created_mask, 32 bits
//
// One word per cycle sustained while the rsp side does not stall; rsp is registered behind the input stage.
// The word sits in an input register, then one pass of wake compares (32 in parallel),
// mask update and a lowest-bit priority encoder updates the state and the rsp register.
// Reset clears all control state and the sleep flags; wake times need no reset.
// A stalled rsp holds the input stage, and req_ready drops only when both stages are full.
`default_nettype none

module priority_thread_scheduler_with_sleep (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    input  wire pts_pkg::req_t  req,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    output pts_pkg::rsp_t       rsp,
    input  wire logic           cfg_wr_en,
    input  wire logic [31:0]    cfg_wr_data
);
    import pts_pkg::*;

    // Lowest set ready bit wins; returns its thread number or idle
    function automatic logic [5:0] pick_thread(input logic [31:0] mask);
        logic [5:0] result;
        result = 6'd0;
        for (int i = 31; i >= 0; i--) begin
            if (mask[i])
            begin
                result = 6'(i + 1);
            end
        end
        return result;
    endfunction

    // Pipeline registers
    logic        s1_valid_reg;
    req_t        s1_reg;
    logic        rsp_valid_reg;
    rsp_t        rsp_reg;
    logic        advance;

    // Scheduler state
    logic [31:0] created_mask_reg;
    logic [31:0] tick_count_reg, tick_count_next;
    logic [31:0] ready_mask_reg, ready_mask_next;
    logic [5:0]  current_thread_reg, current_thread_next;
    logic [31:0] asleep_reg, asleep_next;
    logic [31:0] wake_time_reg [32];

    // Combinational results
    logic [31:0] tick_inc;
    logic [31:0] wake_hit;
    logic [5:0]  pick;
    logic        sw;
    logic        wake_we;
    logic [4:0]  wake_slot;
    logic [31:0] wake_data;

    // Handshake: word moves to rsp when the rsp slot is free or being drained
    assign advance   = s1_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !s1_valid_reg || advance;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Wake compares against the incremented tick count
    assign tick_inc = tick_count_reg + 32'd1;
    always_comb
    begin
        for (int i = 0; i < 32; i++) begin
            wake_hit[i] = asleep_reg[i] && (wake_time_reg[i] == tick_inc);
        end
    end

    // Next state for the word in the input register
    always_comb
    begin
        tick_count_next     = tick_count_reg;
        ready_mask_next     = ready_mask_reg;
        current_thread_next = current_thread_reg;
        asleep_next         = asleep_reg;
        sw                  = 1'b0;
        wake_we             = 1'b0;
        wake_slot           = 5'(current_thread_reg - 6'd1);
        wake_data           = tick_count_reg + s1_reg.sleep_ticks;
        pick                = 6'd0;
        unique case (s1_reg.op)
            OP_TICK:
            begin
                tick_count_next     = tick_inc;
                asleep_next         = asleep_reg & ~wake_hit;
                ready_mask_next     = (ready_mask_reg | wake_hit) & THREAD_MASK;
                pick                = pick_thread(ready_mask_next);
                sw                  = (pick != current_thread_reg);
                current_thread_next = pick;
            end
            OP_SUSPEND:
            begin
                // zero ticks or idle thread: nothing happens
                if ((s1_reg.sleep_ticks != 32'd0) && (current_thread_reg != 6'd0))
                begin
                    wake_we                = 1'b1;
                    asleep_next[wake_slot] = 1'b1;
                    ready_mask_next        = ready_mask_reg & ~(32'd1 << wake_slot)
                                             & THREAD_MASK;
                    pick                   = pick_thread(ready_mask_next);
                    sw                     = (pick != current_thread_reg);
                    current_thread_next    = pick;
                end
            end
            OP_START:
            begin
                ready_mask_next     = created_mask_reg & THREAD_MASK;
                tick_count_next     = 32'd0;
                asleep_next         = 32'd0;
                current_thread_next = 6'd0;
                sw                  = 1'b1;
            end
            default:
            begin
                // unused op code: state unchanged
            end
        endcase
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg       <= 1'b0;
            rsp_valid_reg      <= 1'b0;
            created_mask_reg   <= 32'd0;
            tick_count_reg     <= 32'd0;
            ready_mask_reg     <= 32'd0;
            current_thread_reg <= 6'd0;
            asleep_reg         <= 32'd0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                created_mask_reg <= cfg_wr_data;
            end
            if (req_ready)
            begin
                s1_valid_reg <= req_valid;
            end
            if (advance)
            begin
                rsp_valid_reg      <= 1'b1;
                tick_count_reg     <= tick_count_next;
                ready_mask_reg     <= ready_mask_next;
                current_thread_reg <= current_thread_next;
                asleep_reg         <= asleep_next;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            s1_reg <= req;
        end
        if (advance)
        begin
            rsp_reg.running_thread  <= current_thread_next;
            rsp_reg.previous_thread <= current_thread_reg;
            rsp_reg.switched        <= sw;
            rsp_reg.ready_bits      <= ready_mask_next;
            if (wake_we)
            begin
                wake_time_reg[wake_slot] <= wake_data;
            end
        end
    end

    // No switch means the thread did not change
    a_noswitch_same: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.switched) |-> (rsp.running_thread == rsp.previous_thread))
        else $error("thread changed without switch request");

    // A sleeping thread is never ready
    a_sleep_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (asleep_reg & ready_mask_reg) == 32'd0)
        else $error("thread both asleep and ready");

    // Running thread stays within the thread range
    a_thread_range: assert property (@(posedge clk) disable iff (!rst_n)
        current_thread_reg <= 6'(MAX_THREADS))
        else $error("running thread out of range");

    // Ready mask never holds bits of threads that cannot exist
    a_mask_range: assert property (@(posedge clk) disable iff (!rst_n)
        (ready_mask_reg & ~THREAD_MASK) == 32'd0)
        else $error("ready bit outside thread mask");

endmodule

`default_nettype wire

// ----- test/priority_thread_scheduler_with_sleep_tb.sv -----
// Self-checking testbench for priority_thread_scheduler_with_sleep.
// Uses pts_pkg for the word types and op codes. A built-in scheduler predictor
// produces the expected response words, and these are checked in order.
`timescale 1ns / 100ps

module priority_thread_scheduler_with_sleep_tb;
    import pts_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam time RUN_LIMIT = 3_000_000;

    // DUT connections
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    req_t        req = '0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    rsp_t        rsp;
    logic        cfg_wr_en = 1'b0;
    logic [31:0] cfg_wr_data = '0;

    // Predictor state
    logic [31:0] created_cfg = '0;
    logic [31:0] tick_cnt = '0;
    logic [31:0] ready_set = '0;
    logic [5:0]  cur_thread = '0;
    logic [31:0] wake_at [32];
    logic [31:0] sleeping = '0;

    // Expected response words, oldest first
    rsp_t expected_q[$];
    rsp_t want;

    // Idle control
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_req = 0;
    int hold_left = 0;

    // Bookkeeping
    int errors = 0;
    int words_sent = 0;
    int words_checked = 0;
    int sleeps_taken = 0;
    int wakeups = 0;
    int switches = 0;

    priority_thread_scheduler_with_sleep DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Clock
    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Lowest set ready bit picks the thread; none set means idle
    function automatic logic [5:0] lowest_ready(input logic [31:0] m);
        for (int i = 0; i < 32; i++)
        begin
            if (m[i])
                return 6'(i + 1);
        end
        return 6'd0;
    endfunction

    // Re-pick the running thread; returns 1 on a change
    function automatic logic repick();
        logic [5:0] nxt;
        nxt = lowest_ready(ready_set & THREAD_MASK);
        if (nxt == cur_thread)
            return 1'b0;
        cur_thread = nxt;
        return 1'b1;
    endfunction

    // Scheduler predictor: updates its state and returns the expected word
    function automatic rsp_t sched_step(input req_t w);
        rsp_t r;
        logic [4:0] slot;
        r.previous_thread = cur_thread;
        r.switched = 1'b0;
        case (w.op)
            OP_TICK:
            begin
                tick_cnt = tick_cnt + 32'd1;
                for (int i = 0; i < 32; i++)
                begin
                    if (sleeping[i] && wake_at[i] == tick_cnt)
                    begin
                        sleeping[i] = 1'b0;
                        ready_set[i] = 1'b1;
                        wakeups++;
                    end
                end
                ready_set = ready_set & THREAD_MASK;
                r.switched = repick();
            end
            OP_SUSPEND:
            begin
                // zero ticks or idle thread: nothing happens
                if (w.sleep_ticks != 32'd0 && cur_thread != 6'd0)
                begin
                    slot = 5'(cur_thread - 6'd1);
                    wake_at[slot] = tick_cnt + w.sleep_ticks;
                    sleeping[slot] = 1'b1;
                    ready_set[slot] = 1'b0;
                    ready_set = ready_set & THREAD_MASK;
                    sleeps_taken++;
                    r.switched = repick();
                end
            end
            OP_START:
            begin
                ready_set = created_cfg & THREAD_MASK;
                tick_cnt = '0;
                sleeping = '0;
                cur_thread = 6'd0;
                r.switched = 1'b1;
            end
            default:
            begin
                // unused op code: no change
            end
        endcase
        r.running_thread = cur_thread;
        r.ready_bits = ready_set;
        if (r.switched)
            switches++;
        return r;
    endfunction

    function automatic req_t make_req(input logic [1:0] op, input logic [31:0] ticks);
        req_t w;
        w.op = op;
        w.sleep_ticks = ticks;
        return w;
    endfunction

    // Random word: mostly ticks and short sleeps so threads wake again
    function automatic req_t random_req();
        int sel;
        int tsel;
        logic [31:0] ticks;
        sel = $urandom_range(99);
        tsel = $urandom_range(9);
        if (sel < 50)
            return make_req(OP_TICK, $urandom());
        if (sel < 88)
        begin
            if (tsel == 0)
                ticks = '0;
            else if (tsel <= 6)
                ticks = $urandom_range(6, 1);
            else if (tsel == 7)
                ticks = $urandom_range(40, 7);
            else if (tsel == 8)
                ticks = $urandom();
            else
                ticks = 32'hFFFF_FFFF - $urandom_range(3);
            return make_req(OP_SUSPEND, ticks);
        end
        if (sel < 93)
            return make_req(OP_START, $urandom());
        return make_req(OP_UNUSED, $urandom());
    endfunction

    // Send one word; call at a rising edge, returns at the accepting edge
    task automatic send_word(input req_t w);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 30)
            gap++;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= w;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        words_sent++;
        expected_q.push_back(sched_step(w));
    endtask

    // Stop sending and wait until every expected word has come back
    task automatic wait_for_results();
        req_valid <= 1'b0;
        do
            @(negedge clk);
        while (expected_q.size() != 0);
        repeat (3) @(posedge clk);
    endtask

    // Register write; only while the block is idle
    task automatic write_created_mask(input logic [31:0] m);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= m;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        created_cfg = m;
    endtask

    // Change idle rates away from the rising edge
    task automatic set_mode(input int send_pct, input int recv_pct, input int hold);
        @(negedge clk);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        hold_req = hold;
        @(posedge clk);
    endtask

    // One random phase under one created mask, with a drain halfway
    task automatic run_phase(input int n, input logic [31:0] mask);
        wait_for_results();
        write_created_mask(mask);
        send_word(make_req(OP_START, $urandom()));
        for (int i = 1; i < n; i++)
        begin
            if (i == n / 2)
                wait_for_results();
            send_word(random_req());
        end
        wait_for_results();
    endtask

    // Directed cases: idle suspend, no-op words, sleep and wake, extremes
    task automatic test_directed();
        set_mode(0, 0, 0);
        write_created_mask(32'hFFFF_FFFF);
        send_word(make_req(OP_SUSPEND, 32'd5));          // suspend from idle
        send_word(make_req(OP_TICK, 32'hFFFF_FFFF));     // tick before start
        send_word(make_req(OP_UNUSED, 32'd0));
        send_word(make_req(OP_START, 32'd0));
        send_word(make_req(OP_TICK, 32'd0));             // first pick
        send_word(make_req(OP_TICK, 32'd0));             // same pick, no switch
        send_word(make_req(OP_SUSPEND, 32'd0));          // zero ticks
        send_word(make_req(OP_SUSPEND, 32'd1));
        send_word(make_req(OP_TICK, 32'd0));             // wake on next tick
        send_word(make_req(OP_SUSPEND, 32'hFFFF_FFFF));  // wake time wraps
        send_word(make_req(OP_SUSPEND, 32'd2));
        send_word(make_req(OP_TICK, 32'd0));
        send_word(make_req(OP_TICK, 32'd0));
        send_word(make_req(OP_UNUSED, 32'hFFFF_FFFF));
        send_word(make_req(OP_START, 32'hFFFF_FFFF));    // restart clears sleepers
        wait_for_results();
        // only the lowest priority thread exists
        write_created_mask(32'h8000_0000);
        send_word(make_req(OP_START, 32'd0));
        send_word(make_req(OP_TICK, 32'd0));
        send_word(make_req(OP_SUSPEND, 32'd3));          // falls back to idle
        send_word(make_req(OP_TICK, 32'd0));
        send_word(make_req(OP_TICK, 32'd0));
        send_word(make_req(OP_TICK, 32'd0));
        wait_for_results();
        // no threads at all
        write_created_mask(32'h0000_0000);
        send_word(make_req(OP_START, 32'd0));
        send_word(make_req(OP_TICK, 32'd0));
        send_word(make_req(OP_SUSPEND, 32'd7));
        wait_for_results();
    endtask

    task automatic test_no_idling();
        set_mode(0, 0, 0);
        run_phase(140, 32'hFFFF_FFFF);
        run_phase(140, $urandom() & $urandom() & $urandom());
    endtask

    task automatic test_sender_idle();
        set_mode(56, 0, 0);
        run_phase(140, 32'h0000_0001);
        run_phase(140, $urandom());
    endtask

    task automatic test_receiver_stall();
        set_mode(0, 56, 0);
        run_phase(140, 32'h8000_0000);
        run_phase(140, $urandom() | $urandom());
    endtask

    task automatic test_both_idle();
        set_mode(18, 18, 0);
        run_phase(60, 32'h0000_0000);
        run_phase(220, $urandom() & $urandom());
    endtask

    // Long receiver hold while the sender keeps offering words
    task automatic test_backpressure();
        set_mode(0, 0, 150);
        run_phase(100, $urandom());
    endtask

    // Receiver: random stalls plus an occasional long hold
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req != 0)
            begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left != 0)
            begin
                rsp_ready <= 1'b0;
                hold_left--;
            end
            else
                rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic check_field(input string field, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (got_v !== exp_v)
        begin
            errors++;
            $display("%0t rsp %s: expected %h, got %h", $time, field, exp_v, got_v);
        end
    endtask

    // Response checker
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t rsp word with nothing expected: got %h", $time, rsp);
            end
            else
            begin
                want = expected_q.pop_front();
                words_checked++;
                check_field("running_thread", 32'(want.running_thread),
                            32'(rsp.running_thread));
                check_field("previous_thread", 32'(want.previous_thread),
                            32'(rsp.previous_thread));
                check_field("switched", 32'(want.switched), 32'(rsp.switched));
                check_field("ready_bits", want.ready_bits, rsp.ready_bits);
            end
        end
    end

    // Run limit
    initial
    begin
        #(RUN_LIMIT);
        $display("priority_thread_scheduler_with_sleep: mismatch");
        $finish;
    end

    // Main sequence
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_no_idling();
        test_sender_idle();
        test_receiver_stall();
        test_both_idle();
        test_backpressure();
        wait_for_results();
        repeat (10) @(posedge clk);
        $display("ran %0d request words under several masks and idle patterns;", words_sent);
        $display("checked %0d responses: %0d sleeps, %0d wakeups, %0d switches",
                 words_checked, sleeps_taken, wakeups, switches);
        if (errors == 0)
            $display("priority_thread_scheduler_with_sleep: match");
        else
            $display("priority_thread_scheduler_with_sleep: mismatch");
        $finish;
    end

endmodule
